@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/lswc_pkg.sv @@
// Shared widths, category positions and decision codes for the line sensor window classifier.
package lswc_pkg;
	localparam int PAT_W   = 8;	// sensor pattern
	localparam int DEC_W   = 4;	// decision code
	localparam int NUM_CAT = 7;	// categories per sample
	localparam int CNT_W   = 6;	// per-category count, holds up to 63

	// category bit positions in a mask
	localparam int CAT_NORMAL = 0;
	localparam int CAT_LEFT   = 1;
	localparam int CAT_DLEFT  = 2;
	localparam int CAT_RIGHT  = 3;
	localparam int CAT_DRIGHT = 4;
	localparam int CAT_BLACK  = 5;
	localparam int CAT_WHITE  = 6;

	typedef logic [PAT_W-1:0]   pattern_t;
	typedef logic [DEC_W-1:0]   decision_t;
	typedef logic [NUM_CAT-1:0] cat_mask_t;
	typedef logic [NUM_CAT-1:0][CNT_W-1:0] cat_counts_t;

	// junction decision codes
	typedef enum logic [DEC_W-1:0] {
		DEC_NONE   = 4'd0,
		DEC_CROSS  = 4'd1,
		DEC_T      = 4'd2,
		DEC_TR     = 4'd3,
		DEC_TL     = 4'd4,
		DEC_FAIL_L = 4'd5,
		DEC_FAIL_R = 4'd6,
		DEC_L      = 4'd7,
		DEC_R      = 4'd8,
		DEC_BREAK  = 4'd9,
		DEC_BLACK  = 4'd10
	} decision_code_t;
endpackage

@@ rtl/lswc_if.sv @@
// Valid/ready channel interfaces for samples and decisions.
interface lswc_sample_if
	import lswc_pkg::*;
();
	logic     valid;
	logic     ready;
	pattern_t sensor_pattern;

	modport source (output valid, output sensor_pattern, input ready);
	modport sink (input valid, input sensor_pattern, output ready);
endinterface

interface lswc_decision_if
	import lswc_pkg::*;
();
	logic      valid;
	logic      ready;
	decision_t decision;

	modport source (output valid, output decision, input ready);
	modport sink (input valid, input decision, output ready);
endinterface

@@ rtl/lswc_ram.sv @@
// Generic single write, single read RAM with registered read data.
module lswc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/line_sensor_window_classifier.sv @@
// Line sensor window classifier: top level with history RAM, count pipeline and output queue.
//
// Each accepted 8-bit sensor pattern is classified into a 7-bit category mask
// (normal, left turn, danger left, right turn, danger right, all black, all
// white; several may be set). The last 2*HALF_WINDOW masks live in a ring in
// a single-port-read RAM. Per-category counts cover the newest half window
// (recent) and the half window before it (older); each sample adds its mask
// to recent, moves the sample at the window middle from recent to older, and
// drops the sample leaving the window from older. One prioritized junction
// decision code is returned per sample, computed from the updated counts.
// The two history reads (the leaving slot, then the middle slot) share the
// RAM's one read port, so no new sample is taken while one is reading the
// middle slot. Decisions enter a 4-entry decision queue, which lets new
// samples be taken while earlier decisions wait.
// History slots not yet written since reset read as "no category"; this is
// tracked by a wrap flag on the write pointer, so no clearing pass is needed
// and the block is ready right after reset. HALF_WINDOW may be 32..63.
`include "assert_macros.svh"

module line_sensor_window_classifier
	import lswc_pkg::*;
#(
	parameter int HALF_WINDOW = 50
) (
	input  logic                   clk,
	input  logic                   arst_n,
	lswc_sample_if.sink            samples,
	lswc_decision_if.source        decisions
);
	localparam int RING    = 2 * HALF_WINDOW;
	localparam int AW      = $clog2(RING);
	localparam int QDEPTH  = 4;
	localparam int QPW     = $clog2(QDEPTH);
	localparam int QCW     = $clog2(QDEPTH + 1);

	// pattern tables
	function automatic cat_mask_t classify(input pattern_t p);
		cat_mask_t m;
		m = '0;
		unique case (p)
			8'h18, 8'h30, 8'h60, 8'h0C, 8'h06, 8'h38, 8'h70, 8'hE0, 8'h07, 8'h0E,
			8'h1C: m[CAT_NORMAL] = 1'b1;
			default: ;
		endcase
		unique case (p)
			8'hF0, 8'hF8, 8'hFC, 8'h98, 8'hD8, 8'hB0, 8'hB8, 8'h8C, 8'hCC, 8'h9C,
			8'hDC: m[CAT_LEFT] = 1'b1;
			default: ;
		endcase
		unique case (p)
			8'hE0, 8'hC0, 8'h80: m[CAT_DLEFT] = 1'b1;
			default: ;
		endcase
		unique case (p)
			8'h0F, 8'h1F, 8'h3F, 8'h19, 8'h1B, 8'h31, 8'h33, 8'h37, 8'h39, 8'h3B,
			8'h0D, 8'h1D, 8'h7E, 8'h3C, 8'h66: m[CAT_RIGHT] = 1'b1;
			default: ;
		endcase
		unique case (p)
			8'h01, 8'h03, 8'h07: m[CAT_DRIGHT] = 1'b1;
			default: ;
		endcase
		m[CAT_BLACK] = (p == 8'hFF);
		m[CAT_WHITE] = (p == 8'h00);
		return m;
	endfunction

	// ---------------------------------------------------------------
	// Stage 0: accept, classify, read the leaving slot
	// ---------------------------------------------------------------
	logic [AW-1:0]  wp_q;
	logic           wrapped_q;	// every ring slot has been written once
	logic [QCW-1:0] outst_q;	// requests accepted, decisions not yet taken
	logic           valid_s1, valid_s2, valid_s3;
	logic [AW-1:0]  wp_s1;
	cat_mask_t      mask_s1, mask_s2;
	logic           old_vld_s1, mid_vld_s1, mid_vld_s2;
	cat_mask_t      old_s2;
	logic           in_acc, out_acc;
	logic [AW-1:0]  wp_nxt, mid_s1;
	logic [AW-1:0]  ram_raddr;
	cat_mask_t      ram_rdata;

	// s1 owns the read port, so no new sample is taken while s1 is valid
	assign samples.ready = !valid_s1 && (outst_q < QCW'(QDEPTH));
	assign in_acc        = samples.valid && samples.ready;
	assign wp_nxt        = (wp_q == AW'(RING - 1)) ? '0 : wp_q + AW'(1);
	assign mid_s1        = (wp_s1 >= AW'(HALF_WINDOW)) ? wp_s1 - AW'(HALF_WINDOW)
	                                                   : wp_s1 + AW'(HALF_WINDOW);
	assign ram_raddr     = valid_s1 ? mid_s1 : wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (in_acc) begin
				wp_q <= wp_nxt;
				if (wp_q == AW'(RING - 1)) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// payload pipeline, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wp_s1      <= wp_q;
			mask_s1    <= classify(samples.sensor_pattern);
			old_vld_s1 <= wrapped_q;
			// middle slot lies below the write pointer exactly when wp >= HALF_WINDOW
			mid_vld_s1 <= wrapped_q || (wp_q >= AW'(HALF_WINDOW));
		end
		if (valid_s1) begin
			mask_s2    <= mask_s1;
			mid_vld_s2 <= mid_vld_s1;
			old_s2     <= old_vld_s1 ? ram_rdata : '0;
		end
	end

	// ---------------------------------------------------------------
	// History ring. Stage 1 writes the new mask over the leaving slot
	// (already read) and reads the middle slot.
	// ---------------------------------------------------------------
	lswc_ram #(
		.WIDTH (NUM_CAT),
		.DEPTH (RING)
	) u_hist (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (wp_s1),
		.wdata (mask_s1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// Stage 2: count update
	// ---------------------------------------------------------------
	cat_counts_t recent_q, older_q;
	cat_mask_t   mid_m;

	assign mid_m = mid_vld_s2 ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			older_q  <= '0;
		end else if (valid_s2) begin
			for (int k = 0; k < NUM_CAT; k++) begin
				older_q[k]  <= older_q[k] + CNT_W'(mid_m[k]) - CNT_W'(old_s2[k]);
				recent_q[k] <= recent_q[k] + CNT_W'(mask_s2[k]) - CNT_W'(mid_m[k]);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: decision from the updated counts
	// ---------------------------------------------------------------
	logic [CNT_W:0] lsum, rsum, dlsum, drsum;
	decision_t      dec_s3;

	assign lsum  = {1'b0, older_q[CAT_LEFT]} + {1'b0, recent_q[CAT_LEFT]};
	assign rsum  = {1'b0, older_q[CAT_RIGHT]} + {1'b0, recent_q[CAT_RIGHT]};
	assign dlsum = {1'b0, older_q[CAT_DLEFT]} + {1'b0, recent_q[CAT_DLEFT]};
	assign drsum = {1'b0, older_q[CAT_DRIGHT]} + {1'b0, recent_q[CAT_DRIGHT]};

	always_comb begin
		priority if (recent_q[CAT_BLACK] > CNT_W'(7) && recent_q[CAT_NORMAL] > CNT_W'(10)
		             && recent_q[CAT_WHITE] < CNT_W'(5)) begin
			dec_s3 = DEC_CROSS;
		end else if (recent_q[CAT_BLACK] > CNT_W'(7) && recent_q[CAT_WHITE] > CNT_W'(10)) begin
			dec_s3 = DEC_T;
		end else if (recent_q[CAT_NORMAL] > CNT_W'(15) && recent_q[CAT_RIGHT] > CNT_W'(5)) begin
			dec_s3 = DEC_TR;
		end else if (recent_q[CAT_NORMAL] > CNT_W'(15) && recent_q[CAT_LEFT] > CNT_W'(5)) begin
			dec_s3 = DEC_TL;
		end else if (dlsum > (CNT_W+1)'(5) && recent_q[CAT_WHITE] > CNT_W'(5)) begin
			dec_s3 = DEC_FAIL_L;
		end else if (drsum > (CNT_W+1)'(5) && recent_q[CAT_WHITE] > CNT_W'(5)) begin
			dec_s3 = DEC_FAIL_R;
		end else if (lsum > (CNT_W+1)'(10) && lsum > rsum) begin
			dec_s3 = DEC_L;
		end else if (rsum > (CNT_W+1)'(10) && rsum > lsum) begin
			dec_s3 = DEC_R;
		end else if (recent_q[CAT_WHITE] > CNT_W'(20)) begin
			dec_s3 = DEC_BREAK;
		end else if (recent_q[CAT_BLACK] > CNT_W'(30)) begin
			dec_s3 = DEC_BLACK;
		end else begin
			dec_s3 = DEC_NONE;
		end
	end

	// ---------------------------------------------------------------
	// Decision queue; room is guaranteed by the outstanding count
	// ---------------------------------------------------------------
	decision_t      dq_q [QDEPTH];
	logic [QPW-1:0] dq_wr_q, dq_rd_q;
	logic [QCW-1:0] dq_cnt_q;

	assign decisions.valid    = (dq_cnt_q != '0);
	assign decisions.decision = dq_q[dq_rd_q];
	assign out_acc            = decisions.valid && decisions.ready;

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			dq_q[dq_wr_q] <= dec_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_wr_q  <= '0;
			dq_rd_q  <= '0;
			dq_cnt_q <= '0;
			outst_q  <= '0;
		end else begin
			if (valid_s3) begin
				dq_wr_q <= dq_wr_q + QPW'(1);
			end
			if (out_acc) begin
				dq_rd_q <= dq_rd_q + QPW'(1);
			end
			dq_cnt_q <= dq_cnt_q + QCW'(valid_s3) - QCW'(out_acc);
			outst_q  <= outst_q + QCW'(in_acc) - QCW'(out_acc);
		end
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	logic cnt_in_range;

	always_comb begin
		cnt_in_range = 1'b1;
		for (int k = 0; k < NUM_CAT; k++) begin
			if (recent_q[k] > CNT_W'(HALF_WINDOW) || older_q[k] > CNT_W'(HALF_WINDOW)) begin
				cnt_in_range = 1'b0;
			end
		end
	end

	`ASSERT_IMPLIES(a_s1_s2_excl, clk, arst_n, valid_s1, !valid_s2)
	`ASSERT_IMPLIES(a_queue_le_outst, clk, arst_n, 1'b1, dq_cnt_q <= outst_q)
	`ASSERT_IMPLIES(a_outst_bound, clk, arst_n, 1'b1, outst_q <= QCW'(QDEPTH))
	`ASSERT_IMPLIES(a_counts_bound, clk, arst_n, 1'b1, cnt_in_range)
	`ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_acc, !samples.ready)
endmodule

@@ test/line_sensor_window_classifier_test.sv @@
// Self-checking testbench for the line sensor window classifier.
module line_sensor_window_classifier_test
	import lswc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF        = 50;
	localparam int RING        = 2 * HALF;
	localparam int RAND_ITEMS  = 1100;
	localparam int IDLE_PCT    = 36;
	localparam int DRAIN_WAIT  = 20;	// leave plenty of slack after the last decision
	localparam int CYCLE_LIMIT = 200000;
	localparam int CALM_FROM   = 300;	// accepted-request window with no idling
	localparam int CALM_TO     = 550;
	localparam int PAUSE_AT    = 600;	// second full drain, inside the random part

	localparam int KIND_NOISE = 7;	// stimulus only: any byte

	// One queued sample; hold_for_drain makes the driver wait until every
	// outstanding decision has come back before offering it.
	typedef struct {
		pattern_t pattern;
		bit       hold_for_drain;
	} sample_req_t;

	// Pattern tables that define the turn categories.
	pattern_t tab_normal [11] = '{8'h18, 8'h30, 8'h60, 8'h0C, 8'h06, 8'h38, 8'h70,
		8'hE0, 8'h07, 8'h0E, 8'h1C};
	pattern_t tab_left [11] = '{8'hF0, 8'hF8, 8'hFC, 8'h98, 8'hD8, 8'hB0, 8'hB8,
		8'h8C, 8'hCC, 8'h9C, 8'hDC};
	pattern_t tab_dleft [3] = '{8'hE0, 8'hC0, 8'h80};
	pattern_t tab_right [15] = '{8'h0F, 8'h1F, 8'h3F, 8'h19, 8'h1B, 8'h31, 8'h33,
		8'h37, 8'h39, 8'h3B, 8'h0D, 8'h1D, 8'h7E, 8'h3C, 8'h66};
	pattern_t tab_dright [3] = '{8'h01, 8'h03, 8'h07};

	logic clk;
	logic arst_n;

	lswc_sample_if   sample_ch ();
	lswc_decision_if decision_ch ();

	line_sensor_window_classifier #(
		.HALF_WINDOW(HALF)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_ch),
		.decisions(decision_ch)
	);

	// Shadow window state
	cat_mask_t      mask_ring [RING];
	int unsigned    ring_pos;
	cat_counts_t    recent_cnt;
	cat_counts_t    older_cnt;

	sample_req_t    pending_samples[$];
	decision_code_t expected_decisions[$];
	int             accepted_count;
	int             error_count;
	int             cycle_count;

	// No idling on either side while the accepted count is inside this window.
	wire calm = (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------
	function automatic cat_mask_t classify_pattern(pattern_t p);
		cat_mask_t m;
		m = '0;
		foreach (tab_normal[i]) if (tab_normal[i] == p) m[CAT_NORMAL] = 1'b1;
		foreach (tab_left[i])   if (tab_left[i] == p)   m[CAT_LEFT]   = 1'b1;
		foreach (tab_dleft[i])  if (tab_dleft[i] == p)  m[CAT_DLEFT]  = 1'b1;
		foreach (tab_right[i])  if (tab_right[i] == p)  m[CAT_RIGHT]  = 1'b1;
		foreach (tab_dright[i]) if (tab_dright[i] == p) m[CAT_DRIGHT] = 1'b1;
		if (p == 8'hFF) m[CAT_BLACK] = 1'b1;
		if (p == 8'h00) m[CAT_WHITE] = 1'b1;
		return m;
	endfunction

	// Counts saturate at both ends; with a half window of 50 neither end is
	// ever reached, but the guard keeps the shadow honest.
	function automatic cat_counts_t apply_mask(cat_counts_t c, cat_mask_t m, bit up);
		for (int k = 0; k < NUM_CAT; k++) begin
			if (m[k]) begin
				if (up && c[k] != '1)
					c[k] = c[k] + 1'b1;
				else if (!up && c[k] != '0)
					c[k] = c[k] - 1'b1;
			end
		end
		return c;
	endfunction

	// Prioritized junction decision from the updated counts.
	function automatic decision_code_t junction_decision(cat_counts_t r, cat_counts_t o);
		int lsum;
		int rsum;
		lsum = int'(o[CAT_LEFT]) + int'(r[CAT_LEFT]);
		rsum = int'(o[CAT_RIGHT]) + int'(r[CAT_RIGHT]);
		if (r[CAT_BLACK] > 7 && r[CAT_NORMAL] > 10 && r[CAT_WHITE] < 5) return DEC_CROSS;
		if (r[CAT_BLACK] > 7 && r[CAT_WHITE] > 10) return DEC_T;
		if (r[CAT_NORMAL] > 15 && r[CAT_RIGHT] > 5) return DEC_TR;
		if (r[CAT_NORMAL] > 15 && r[CAT_LEFT] > 5) return DEC_TL;
		if (int'(o[CAT_DLEFT]) + int'(r[CAT_DLEFT]) > 5 && r[CAT_WHITE] > 5)
			return DEC_FAIL_L;
		if (int'(o[CAT_DRIGHT]) + int'(r[CAT_DRIGHT]) > 5 && r[CAT_WHITE] > 5)
			return DEC_FAIL_R;
		if (lsum > 10 && lsum > rsum) return DEC_L;
		if (rsum > 10 && rsum > lsum) return DEC_R;
		if (r[CAT_WHITE] > 20) return DEC_BREAK;
		if (r[CAT_BLACK] > 30) return DEC_BLACK;
		return DEC_NONE;
	endfunction

	// Push one sample through the shadow window: the slot at ring_pos leaves
	// the older half, the slot half a window ahead moves from recent to older,
	// and the new mask joins recent.
	function automatic decision_code_t advance_window(pattern_t p);
		cat_mask_t   m;
		int unsigned mid;
		m   = classify_pattern(p);
		mid = (ring_pos + HALF) % RING;
		older_cnt  = apply_mask(older_cnt, mask_ring[ring_pos], 1'b0);
		recent_cnt = apply_mask(recent_cnt, mask_ring[mid], 1'b0);
		older_cnt  = apply_mask(older_cnt, mask_ring[mid], 1'b1);
		recent_cnt = apply_mask(recent_cnt, m, 1'b1);
		mask_ring[ring_pos] = m;
		ring_pos = (ring_pos + 1) % RING;
		return junction_decision(recent_cnt, older_cnt);
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	function automatic pattern_t pick_pattern(int kind);
		case (kind)
			CAT_NORMAL: return tab_normal[$urandom_range($size(tab_normal) - 1)];
			CAT_LEFT:   return tab_left[$urandom_range($size(tab_left) - 1)];
			CAT_DLEFT:  return tab_dleft[$urandom_range($size(tab_dleft) - 1)];
			CAT_RIGHT:  return tab_right[$urandom_range($size(tab_right) - 1)];
			CAT_DRIGHT: return tab_dright[$urandom_range($size(tab_dright) - 1)];
			CAT_BLACK:  return 8'hFF;
			CAT_WHITE:  return 8'h00;
			default:    return pattern_t'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_sample(pattern_t p, bit hold);
		sample_req_t req;
		req.pattern        = p;
		req.hold_for_drain = hold;
		pending_samples.push_back(req);
	endtask

	task automatic load_samples();
		pattern_t directed [$];
		int       kind;
		int       run_len;
		int       queued;
		// Edges: all white and all black, overlaps (E0 is normal and danger
		// left, 07 normal and danger right), one member of each table, and a
		// few off-table bytes. The first ones also read the empty history.
		directed = '{8'h00, 8'hFF, 8'hE0, 8'h07, 8'h18, 8'hF0, 8'h80, 8'h0F,
			8'h01, 8'h7E, 8'hC0, 8'h03, 8'h66, 8'hDC, 8'hAA, 8'h55, 8'h81, 8'h00,
			8'hFF, 8'h3C};
		foreach (directed[i])
			queue_sample(directed[i], 1'b0);

		// Random part: runs of one category so the half-window counts climb
		// past the decision thresholds, broken up by noise runs and stray random
		// bytes. Mixed short runs produce cross and T combinations.
		queued = 0;
		while (queued < RAND_ITEMS) begin
			kind    = $urandom_range(KIND_NOISE + 1);
			run_len = ($urandom_range(3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 15);
			for (int i = 0; i < run_len && queued < RAND_ITEMS; i++) begin
				// first random item and the item at PAUSE_AT wait for a full drain
				queue_sample(($urandom_range(9) == 0) ? pick_pattern(KIND_NOISE)
					: pick_pattern(kind),
					queued == 0 || queued == PAUSE_AT - $size(directed));
				queued++;
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver: offers queued samples, records the prediction on acceptance.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		sample_req_t next_req;
		if (!arst_n) begin
			sample_ch.valid          <= 1'b0;
			sample_ch.sensor_pattern <= '0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_decisions.push_back(advance_window(sample_ch.sensor_pattern));
				accepted_count++;
			end
			// Only touch the channel when nothing is waiting on it.
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pending_samples.size() != 0
					&& !(pending_samples[0].hold_for_drain && expected_decisions.size() != 0)
					&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
					next_req = pending_samples.pop_front();
					sample_ch.valid          <= 1'b1;
					sample_ch.sensor_pattern <= next_req.pattern;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: random back-pressure, compares each decision in order.
	// ---------------------------------------------------------------------
	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		decision_code_t want;
		if (!arst_n) begin
			decision_ch.ready <= 1'b0;
		end else begin
			if (decision_ch.valid && decision_ch.ready) begin
				if (expected_decisions.size() == 0) begin
					report_mismatch($sformatf("decision %0d with no sample outstanding",
						decision_ch.decision));
				end else begin
					want = expected_decisions.pop_front();
					if (decision_ch.decision !== want)
						report_mismatch($sformatf("decision got %0d want %0d (%s)",
							decision_ch.decision, want, want.name()));
				end
			end
			decision_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence: reset, run stimulus, drain, verdict.
	// ---------------------------------------------------------------------
	initial begin
		sample_ch.valid          = 1'b0;
		sample_ch.sensor_pattern = '0;
		decision_ch.ready        = 1'b0;
		arst_n                   = 1'b0;
		// Reset history counts as no category.
		foreach (mask_ring[i])
			mask_ring[i] = '0;
		ring_pos       = 0;
		recent_cnt     = '0;
		older_cnt      = '0;
		accepted_count = 0;
		error_count    = 0;
		cycle_count    = 0;
		load_samples();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_samples.size() != 0 || sample_ch.valid)
			@(posedge clk);
		while (expected_decisions.size() != 0)
			@(posedge clk);
		// catch any stray decision after the last expected one
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
